// ----- sv/adts_header_sync_parser_core_defines.svh -----
// Assertion macros shared by the ADTS header parser RTL.
`ifndef ADTS_HEADER_SYNC_PARSER_CORE_DEFINES_SVH
`define ADTS_HEADER_SYNC_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock edge outside reset.
`define AHSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ahsp assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define AHSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ahsp assertion failed");
`else
`define AHSP_ASSERT_IMP(lbl, ante, cons)
`define AHSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/ahsp_pkg.sv -----
// Types and constants for the ADTS header sync parser.
`timescale 1ns / 1ps

package ahsp_pkg;

  // Sync pattern and header geometry
  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE   = 4'hF;
  localparam logic [2:0] SYNC_HELD     = 3'd2;
  localparam logic [2:0] LAST_HELD     = 3'd6;
  localparam int unsigned HdrBytes     = 7;
  localparam int unsigned RateReserved = 13;
  localparam int unsigned HoldBits     = 8 * 5;
  localparam int unsigned BodyBits     = 8 * 6;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LAYER  = 2'd1,
    ERR_LENGTH = 2'd2,
    ERR_RATE   = 2'd3
  } ahsp_err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } ahsp_in_t;

  typedef struct packed {
    ahsp_err_e   error_code;
    logic        mpeg_id;
    logic [1:0]  layer_bits;
    logic        crc_absent;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
    logic [4:0]  misc_bits;
    logic [12:0] frame_length;
    logic [10:0] buffer_fullness;
    logic [1:0]  raw_block_count;
  } ahsp_out_t;

endpackage

// ----- sv/adts_header_sync_parser_core.sv -----
// Top level of the ADTS header sync parser: sync hunt, header collect, result buffer.
// Takes one byte per cycle unless stalled; a header result is loaded into the result
// register when its seventh byte is accepted, or into one skid entry if that register is held.
// Throughput is one byte per cycle; input stalls only while the skid entry is full.
// Reset (asynchronous, active low) clears hunt/collect state and both result valids.
`timescale 1ns / 1ps
`include "adts_header_sync_parser_core_defines.svh"

module adts_header_sync_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ahsp_pkg::ahsp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ahsp_pkg::ahsp_out_t out_data_o
);

  logic [7:0]                    prev_byte_q, prev_byte_d;
  logic                          prev_valid_q, prev_valid_d;
  logic                          collecting_q, collecting_d;
  logic [2:0]                    held_q, held_d;
  logic [ahsp_pkg::HoldBits-1:0] hdr_q, hdr_d;
  ahsp_pkg::ahsp_out_t           out_q, skid_q, res_new;
  logic                          out_valid_q, skid_valid_q;
  logic                          in_acc, out_take, res_fire, sync_hit;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;

  assign sync_hit = prev_valid_q && (prev_byte_q == ahsp_pkg::SYNC_BYTE) &&
                    (in_data_i.data_byte[7:4] == ahsp_pkg::SYNC_NIBBLE);
  assign res_fire = in_acc && collecting_q && (held_q == ahsp_pkg::LAST_HELD);

  // Unpack the completed header with the current byte as its last
  ahsp_unpack u_unpack (
    .hdr_i ({hdr_q, in_data_i.data_byte}),
    .res_o (res_new)
  );

  // Hunt and collect next state
  always_comb begin
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    collecting_d = collecting_q;
    held_d       = held_q;
    hdr_d        = hdr_q;
    if (in_acc) begin
      if (collecting_q) begin
        hdr_d = {hdr_q[ahsp_pkg::HoldBits-9:0], in_data_i.data_byte};
        if (held_q == ahsp_pkg::LAST_HELD) begin
          collecting_d = 1'b0;
          held_d       = 3'd0;
          prev_valid_d = 1'b0;
        end else begin
          held_d = held_q + 3'd1;
        end
      end else if (sync_hit) begin
        hdr_d        = {hdr_q[ahsp_pkg::HoldBits-9:0], in_data_i.data_byte};
        held_d       = ahsp_pkg::SYNC_HELD;
        collecting_d = 1'b1;
        prev_valid_d = 1'b0;
      end else begin
        prev_byte_d  = in_data_i.data_byte;
        prev_valid_d = 1'b1;
      end
      // Drop partial state at a buffer end
      if (in_data_i.buffer_end) begin
        collecting_d = 1'b0;
        held_d       = 3'd0;
        prev_valid_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      collecting_q <= 1'b0;
      held_q       <= 3'd0;
    end else begin
      prev_valid_q <= prev_valid_d;
      collecting_q <= collecting_d;
      held_q       <= held_d;
    end
  end

  // Byte payload
  always_ff @(posedge clk_i) begin
    prev_byte_q <= prev_byte_d;
    hdr_q       <= hdr_d;
  end

  // Result register and skid entry valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register and skid entry payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_fire) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  `AHSP_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q)
  `AHSP_ASSERT_IMP(a_held_range, collecting_q, (held_q >= ahsp_pkg::SYNC_HELD) && (held_q <= ahsp_pkg::LAST_HELD))
  `AHSP_ASSERT_IMP(a_hunt_empty, !collecting_q, held_q == 3'd0)
  `AHSP_ASSERT_NXT(a_header_gives_beat, res_fire, out_valid_q)

endmodule

// ----- sv/ahsp_unpack.sv -----
// Field unpacking and validity checks for one ADTS header (fixed and variable parts).
`timescale 1ns / 1ps

module ahsp_unpack (
  input  logic [ahsp_pkg::BodyBits-1:0] hdr_i,
  output ahsp_pkg::ahsp_out_t           res_o
);

  logic [7:0] b1, b2, b3, b4, b5, b6;

  // Split the header body (second through seventh byte)
  assign b1 = hdr_i[47:40];
  assign b2 = hdr_i[39:32];
  assign b3 = hdr_i[31:24];
  assign b4 = hdr_i[23:16];
  assign b5 = hdr_i[15:8];
  assign b6 = hdr_i[7:0];

  // Unpack fields and pick the first failing check
  always_comb begin
    res_o.mpeg_id         = b1[3];
    res_o.layer_bits      = b1[2:1];
    res_o.crc_absent      = b1[0];
    res_o.profile         = b2[7:6];
    res_o.rate_index      = b2[5:2];
    res_o.channel_config  = {b2[0], b3[7:6]};
    res_o.misc_bits       = {b2[1], b3[5:2]};
    res_o.frame_length    = {b3[1:0], b4, b5[7:5]};
    res_o.buffer_fullness = {b5[4:0], b6[7:2]};
    res_o.raw_block_count = b6[1:0];

    if (res_o.layer_bits != 2'd0) begin
      res_o.error_code = ahsp_pkg::ERR_LAYER;
    end else if (res_o.frame_length < 13'(ahsp_pkg::HdrBytes)) begin
      res_o.error_code = ahsp_pkg::ERR_LENGTH;
    end else if (res_o.rate_index >= 4'(ahsp_pkg::RateReserved)) begin
      res_o.error_code = ahsp_pkg::ERR_RATE;
    end else begin
      res_o.error_code = ahsp_pkg::ERR_OK;
    end
  end

endmodule
